@@ hw/rtl/daylight_colour_temperature_rgb_unit_defines.svh @@
// Assertion macros for the daylight colour temperature unit.
`ifndef DAYLIGHT_COLOUR_TEMPERATURE_RGB_UNIT_DEFINES_SVH
`define DAYLIGHT_COLOUR_TEMPERATURE_RGB_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCTR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dctr_pkg.sv @@
// Shared constants, types and curve tables for the daylight colour unit.
`timescale 1ns / 1ps
`default_nettype none
package dctr_pkg;

  localparam int unsigned SecondW = 17;
  localparam int unsigned BrightW = 7;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned KelvinW = 13;

  localparam logic [SecondW-1:0] WINDOW_START = 17'd21600;
  localparam logic [SecondW-1:0] WINDOW_END   = 17'd64800;
  localparam logic [15:0]        SEG_SECONDS  = 16'd7200;
  localparam logic [KelvinW-1:0] NIGHT_KELVIN = 13'd1900;
  localparam logic [BrightW-1:0] BRIGHT_MAX   = 7'd100;
  localparam logic [7:0]         TABLE_BASE   = 8'd19;
  localparam logic [7:0]         TABLE_LAST   = 8'd47;
  localparam logic [7:0]         FULL_LEVEL   = 8'd255;

  // floor(2^28 / 225): quotient by 225 is exact or one low
  localparam logic [20:0] RECIP225       = 21'd1193046;
  localparam logic [19:0] SEG_DIV_REST   = 20'd225;
  // 5243 / 2^17 approximates 1/25 closely enough for values below 8192
  localparam logic [12:0] RECIP25        = 13'd5243;

  typedef struct packed {
    logic               valid;
    logic [KelvinW-1:0] kelvin;
    logic [BrightW-1:0] bright;
  } dctr_kel_t;

  // Floor of n / 100 for n below 25600: (n / 4) / 25 by reciprocal.
  function automatic logic [7:0] div100(input logic [14:0] n);
    logic [25:0] prod;
    prod = 26'(n[14:2]) * 26'(RECIP25);
    return prod[24:17];
  endfunction

  // Start offset of each two-hour segment inside the daylight window.
  function automatic logic [15:0] seg_base(input logic [2:0] seg);
    logic [15:0] base;
    unique case (seg)
      3'd0:    base = 16'd0;
      3'd1:    base = 16'd7200;
      3'd2:    base = 16'd14400;
      3'd3:    base = 16'd21600;
      3'd4:    base = 16'd28800;
      3'd5:    base = 16'd36000;
      default: base = 16'd0;
    endcase
    return base;
  endfunction

  // Kelvin at the start of each segment.
  function automatic logic [KelvinW-1:0] seg_lo(input logic [2:0] seg);
    logic [KelvinW-1:0] k;
    unique case (seg)
      3'd0:    k = 13'd1900;
      3'd1:    k = 13'd3000;
      3'd2:    k = 13'd4000;
      3'd3:    k = 13'd6600;
      3'd4:    k = 13'd4000;
      3'd5:    k = 13'd3000;
      default: k = NIGHT_KELVIN;
    endcase
    return k;
  endfunction

  // Magnitude of the kelvin change across each segment.
  function automatic logic [11:0] seg_diff(input logic [2:0] seg);
    logic [11:0] d;
    unique case (seg)
      3'd0:    d = 12'd1100;
      3'd1:    d = 12'd1000;
      3'd2:    d = 12'd2600;
      3'd3:    d = 12'd2600;
      3'd4:    d = 12'd1000;
      3'd5:    d = 12'd1100;
      default: d = 12'd0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] green_curve(input logic [5:0] idx);
    logic [7:0] v;
    unique case (idx)
      6'd0:  v = 8'd131;  6'd1:  v = 8'd136;  6'd2:  v = 8'd141;  6'd3:  v = 8'd146;
      6'd4:  v = 8'd150;  6'd5:  v = 8'd155;  6'd6:  v = 8'd159;  6'd7:  v = 8'd162;
      6'd8:  v = 8'd166;  6'd9:  v = 8'd170;  6'd10: v = 8'd173;  6'd11: v = 8'd177;
      6'd12: v = 8'd180;  6'd13: v = 8'd183;  6'd14: v = 8'd186;  6'd15: v = 8'd189;
      6'd16: v = 8'd192;  6'd17: v = 8'd195;  6'd18: v = 8'd198;  6'd19: v = 8'd200;
      6'd20: v = 8'd203;  6'd21: v = 8'd205;  6'd22: v = 8'd208;  6'd23: v = 8'd210;
      6'd24: v = 8'd213;  6'd25: v = 8'd215;  6'd26: v = 8'd217;  6'd27: v = 8'd219;
      6'd28: v = 8'd221;  6'd29: v = 8'd223;  6'd30: v = 8'd226;  6'd31: v = 8'd228;
      6'd32: v = 8'd229;  6'd33: v = 8'd231;  6'd34: v = 8'd233;  6'd35: v = 8'd235;
      6'd36: v = 8'd237;  6'd37: v = 8'd239;  6'd38: v = 8'd241;  6'd39: v = 8'd242;
      6'd40: v = 8'd244;  6'd41: v = 8'd246;  6'd42: v = 8'd247;  6'd43: v = 8'd249;
      6'd44: v = 8'd251;  6'd45: v = 8'd252;  6'd46: v = 8'd254;  6'd47: v = 8'd255;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] blue_curve(input logic [5:0] idx);
    logic [7:0] v;
    unique case (idx)
      6'd0:  v = 8'd0;    6'd1:  v = 8'd13;   6'd2:  v = 8'd27;   6'd3:  v = 8'd39;
      6'd4:  v = 8'd50;   6'd5:  v = 8'd60;   6'd6:  v = 8'd70;   6'd7:  v = 8'd79;
      6'd8:  v = 8'd87;   6'd9:  v = 8'd95;   6'd10: v = 8'd102;  6'd11: v = 8'd109;
      6'd12: v = 8'd116;  6'd13: v = 8'd123;  6'd14: v = 8'd129;  6'd15: v = 8'd135;
      6'd16: v = 8'd140;  6'd17: v = 8'd146;  6'd18: v = 8'd151;  6'd19: v = 8'd156;
      6'd20: v = 8'd161;  6'd21: v = 8'd166;  6'd22: v = 8'd170;  6'd23: v = 8'd175;
      6'd24: v = 8'd179;  6'd25: v = 8'd183;  6'd26: v = 8'd187;  6'd27: v = 8'd191;
      6'd28: v = 8'd195;  6'd29: v = 8'd198;  6'd30: v = 8'd202;  6'd31: v = 8'd205;
      6'd32: v = 8'd209;  6'd33: v = 8'd212;  6'd34: v = 8'd215;  6'd35: v = 8'd219;
      6'd36: v = 8'd222;  6'd37: v = 8'd225;  6'd38: v = 8'd228;  6'd39: v = 8'd231;
      6'd40: v = 8'd234;  6'd41: v = 8'd236;  6'd42: v = 8'd239;  6'd43: v = 8'd242;
      6'd44: v = 8'd244;  6'd45: v = 8'd247;  6'd46: v = 8'd255;  6'd47: v = 8'd255;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dctr_kelvin.sv @@
// Five-stage pipeline from time of day to interpolated colour temperature.
`timescale 1ns / 1ps
`default_nettype none
module dctr_kelvin (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [dctr_pkg::SecondW-1:0] in_second,
  input  wire logic [dctr_pkg::BrightW-1:0] in_bright,
  output dctr_pkg::dctr_kel_t              kel_o
);

  // stage 1: window test, segment and offset
  logic                        s1_v_r, s1_win_r, s1_win_nxt;
  logic [2:0]                  s1_seg_r, s1_seg_nxt;
  logic [12:0]                 s1_d_r, s1_d_nxt;
  logic [dctr_pkg::BrightW-1:0] s1_b_r, s1_b_nxt;
  logic [15:0]                 x;
  logic [15:0]                 d_full;

  always_comb begin
    s1_win_nxt = (in_second >= dctr_pkg::WINDOW_START) && (in_second < dctr_pkg::WINDOW_END);
    x = 16'(in_second - dctr_pkg::WINDOW_START);
    if (x >= 16'd36000)      s1_seg_nxt = 3'd5;
    else if (x >= 16'd28800) s1_seg_nxt = 3'd4;
    else if (x >= 16'd21600) s1_seg_nxt = 3'd3;
    else if (x >= 16'd14400) s1_seg_nxt = 3'd2;
    else if (x >= dctr_pkg::SEG_SECONDS) s1_seg_nxt = 3'd1;
    else                     s1_seg_nxt = 3'd0;
    d_full = x - dctr_pkg::seg_base(s1_seg_nxt);
    s1_d_nxt = d_full[12:0];
    s1_b_nxt = (in_bright > dctr_pkg::BRIGHT_MAX) ? dctr_pkg::BRIGHT_MAX : in_bright;
  end

  // stage 2: offset times kelvin span
  logic                        s2_v_r, s2_win_r, s2_rise_r, s2_rise_nxt;
  logic [24:0]                 s2_p_r, s2_p_nxt;
  logic [dctr_pkg::KelvinW-1:0] s2_lo_r;
  logic [dctr_pkg::BrightW-1:0] s2_b_r;

  always_comb begin
    s2_p_nxt    = 25'(s1_d_r) * 25'(dctr_pkg::seg_diff(s1_seg_r));
    s2_rise_nxt = (s1_seg_r < 3'd3);
  end

  // stage 3: estimate of product / 7200 as (product / 32) / 225
  logic                        s3_v_r, s3_win_r, s3_rise_r;
  logic [19:0]                 s3_n_r;
  logic [12:0]                 s3_q_r, s3_q_nxt;
  logic [dctr_pkg::KelvinW-1:0] s3_lo_r;
  logic [dctr_pkg::BrightW-1:0] s3_b_r;
  logic [40:0]                 q_prod;

  always_comb begin
    q_prod   = 41'(s2_p_r[24:5]) * 41'(dctr_pkg::RECIP225);
    s3_q_nxt = q_prod[40:28];
  end

  // stage 4: correct the estimate by at most one
  logic                        s4_v_r, s4_win_r, s4_rise_r;
  logic [12:0]                 s4_q_r, s4_q_nxt;
  logic [dctr_pkg::KelvinW-1:0] s4_lo_r;
  logic [dctr_pkg::BrightW-1:0] s4_b_r;
  logic [19:0]                 rem;

  always_comb begin
    rem = s3_n_r - 20'(s3_q_r) * dctr_pkg::SEG_DIV_REST;
    s4_q_nxt = (rem >= dctr_pkg::SEG_DIV_REST) ? s3_q_r + 13'd1 : s3_q_r;
  end

  // stage 5: final kelvin
  dctr_pkg::dctr_kel_t          kel_nxt;
  logic                         kel_v_r;
  logic [dctr_pkg::KelvinW-1:0] kel_k_r;
  logic [dctr_pkg::BrightW-1:0] kel_b_r;

  always_comb begin
    kel_nxt.valid  = s4_v_r;
    kel_nxt.bright = s4_b_r;
    if (!s4_win_r)      kel_nxt.kelvin = dctr_pkg::NIGHT_KELVIN;
    else if (s4_rise_r) kel_nxt.kelvin = s4_lo_r + s4_q_r;
    else                kel_nxt.kelvin = s4_lo_r - s4_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      kel_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      kel_v_r <= kel_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_win_r <= s1_win_nxt;
      s1_seg_r <= s1_seg_nxt;
      s1_d_r   <= s1_d_nxt;
      s1_b_r   <= s1_b_nxt;

      s2_win_r  <= s1_win_r;
      s2_rise_r <= s2_rise_nxt;
      s2_p_r    <= s2_p_nxt;
      s2_lo_r   <= dctr_pkg::seg_lo(s1_seg_r);
      s2_b_r    <= s1_b_r;

      s3_win_r  <= s2_win_r;
      s3_rise_r <= s2_rise_r;
      s3_n_r    <= s2_p_r[24:5];
      s3_q_r    <= s3_q_nxt;
      s3_lo_r   <= s2_lo_r;
      s3_b_r    <= s2_b_r;

      s4_win_r  <= s3_win_r;
      s4_rise_r <= s3_rise_r;
      s4_q_r    <= s4_q_nxt;
      s4_lo_r   <= s3_lo_r;
      s4_b_r    <= s3_b_r;

      kel_k_r <= kel_nxt.kelvin;
      kel_b_r <= kel_nxt.bright;
    end
  end

  assign kel_o = '{valid: kel_v_r, kelvin: kel_k_r, bright: kel_b_r};

endmodule
`default_nettype wire

@@ hw/rtl/dctr_colour.sv @@
// Three-stage pipeline from colour temperature to brightness-scaled RGB levels.
`timescale 1ns / 1ps
`default_nettype none
module dctr_colour (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire dctr_pkg::dctr_kel_t          kel_i,
  output logic                              out_valid,
  output logic [dctr_pkg::LevelW-1:0]       out_red_level,
  output logic [dctr_pkg::LevelW-1:0]       out_green_level,
  output logic [dctr_pkg::LevelW-1:0]       out_blue_level,
  output logic [dctr_pkg::KelvinW-1:0]      out_colour_kelvin
);

  // stage 1: kelvin / 100, table index, curve lookup
  logic                         c1_v_r;
  logic [dctr_pkg::KelvinW-1:0] c1_k_r;
  logic [dctr_pkg::BrightW-1:0] c1_b_r;
  logic [7:0]                   c1_g_r, c1_bl_r;
  logic [7:0]                   t, t_off;
  logic [5:0]                   idx;

  always_comb begin
    t     = dctr_pkg::div100(15'(kel_i.kelvin));
    t_off = t - dctr_pkg::TABLE_BASE;
    if (t < dctr_pkg::TABLE_BASE)        idx = 6'd0;
    else if (t_off > dctr_pkg::TABLE_LAST) idx = 6'(dctr_pkg::TABLE_LAST);
    else                                  idx = t_off[5:0];
  end

  // stage 2: level times brightness
  logic                         c2_v_r;
  logic [dctr_pkg::KelvinW-1:0] c2_k_r;
  logic [14:0]                  c2_pr_r, c2_pg_r, c2_pb_r;

  // stage 3: divide by 100 into the output register
  logic                         c3_v_r;
  logic [dctr_pkg::KelvinW-1:0] c3_k_r;
  logic [7:0]                   c3_r_r, c3_g_r, c3_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= kel_i.valid;
      c2_v_r <= c1_v_r;
      c3_v_r <= c2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_k_r  <= kel_i.kelvin;
      c1_b_r  <= kel_i.bright;
      c1_g_r  <= dctr_pkg::green_curve(idx);
      c1_bl_r <= dctr_pkg::blue_curve(idx);

      c2_k_r  <= c1_k_r;
      c2_pr_r <= 15'(dctr_pkg::FULL_LEVEL) * 15'(c1_b_r);
      c2_pg_r <= 15'(c1_g_r) * 15'(c1_b_r);
      c2_pb_r <= 15'(c1_bl_r) * 15'(c1_b_r);

      c3_k_r <= c2_k_r;
      c3_r_r <= dctr_pkg::div100(c2_pr_r);
      c3_g_r <= dctr_pkg::div100(c2_pg_r);
      c3_b_r <= dctr_pkg::div100(c2_pb_r);
    end
  end

  assign out_valid         = c3_v_r;
  assign out_red_level     = c3_r_r;
  assign out_green_level   = c3_g_r;
  assign out_blue_level    = c3_b_r;
  assign out_colour_kelvin = c3_k_r;

endmodule
`default_nettype wire

@@ hw/rtl/daylight_colour_temperature_rgb_unit.sv @@
// Throughput: one item per cycle when not stalled; all stages are plain registers.
// Stall: when the output register holds a result that is stalled, all stages hold.
// Reset (synchronous, rst_n low): clears every stage valid bit; data is not reset.
// No clearing pass and no startup delay: items are taken from the first cycle.
`timescale 1ns / 1ps
`default_nettype none
module daylight_colour_temperature_rgb_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [dctr_pkg::SecondW-1:0] in_second_of_day,
  input  wire logic [dctr_pkg::BrightW-1:0] in_brightness_percent,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [dctr_pkg::LevelW-1:0]       out_red_level,
  output logic [dctr_pkg::LevelW-1:0]       out_green_level,
  output logic [dctr_pkg::LevelW-1:0]       out_blue_level,
  output logic [dctr_pkg::KelvinW-1:0]      out_colour_kelvin
);

  // Advance the whole pipe unless a finished result is waiting on a stalled
  // consumer. An empty output register always lets the pipe move, so bubbles
  // never block a transfer.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Time of day -> kelvin: window test, segment pick, span multiply,
  // reciprocal divide by 7200 with a one-step correction, final add/subtract.
  dctr_pkg::dctr_kel_t kel;

  dctr_kelvin u_kelvin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_second (in_second_of_day),
    .in_bright (in_brightness_percent),
    .kel_o     (kel)
  );

  // Kelvin -> curve lookup, brightness multiply, reciprocal divide by 100.
  // The last stage of this unit is the output register.
  dctr_colour u_colour (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .kel_i             (kel),
    .out_valid         (out_valid),
    .out_red_level     (out_red_level),
    .out_green_level   (out_green_level),
    .out_blue_level    (out_blue_level),
    .out_colour_kelvin (out_colour_kelvin)
  );

endmodule
`default_nettype wire

@@ hw/rtl/dctr_checker.sv @@
// Port-level checks for the daylight colour unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "daylight_colour_temperature_rgb_unit_defines.svh"
module dctr_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [dctr_pkg::SecondW-1:0] in_second_of_day,
  input wire logic [dctr_pkg::BrightW-1:0] in_brightness_percent,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [dctr_pkg::LevelW-1:0]  out_red_level,
  input wire logic [dctr_pkg::LevelW-1:0]  out_green_level,
  input wire logic [dctr_pkg::LevelW-1:0]  out_blue_level,
  input wire logic [dctr_pkg::KelvinW-1:0] out_colour_kelvin
);

  logic in_seen;
  assign in_seen = in_valid || (in_second_of_day != '0) || (in_brightness_percent != '0);

  // input side stalls only behind a stalled result
  `DCTR_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall || (in_seen && in_stall), out_valid && out_stall, "input stalled without a stalled result")

  // kelvin stays inside the daylight curve
  `DCTR_ASSERT_IMP(a_kelvin_range, clk, rst_n, out_valid, (out_colour_kelvin >= 13'd1900) && (out_colour_kelvin <= 13'd6600), "kelvin out of range")

  // red is full scale, so no channel exceeds it at the same brightness
  `DCTR_ASSERT_IMP(a_red_dominant, clk, rst_n, out_valid, (out_red_level >= out_green_level) && (out_red_level >= out_blue_level), "channel above red")

  // a stalled result holds
  `DCTR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_colour_kelvin) && $stable(out_red_level) && $stable(out_green_level) && $stable(out_blue_level), "stalled result changed")

endmodule

bind daylight_colour_temperature_rgb_unit dctr_checker u_dctr_checker (.*);
`default_nettype wire

@@ tb/sv/tb_daylight_colour_temperature_rgb_unit.sv @@
// Self-checking testbench for the daylight colour temperature unit.
`timescale 1ns / 1ps
module tb_daylight_colour_temperature_rgb_unit;

  // Clock, transfer limits and pacing knobs.
  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_SAMPLES = 2000;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned LONG_HOLD      = 120;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned REPORT_LIMIT   = 10;

  // Daylight schedule: the window spans 06:00 to 18:00 in two-hour segments.
  localparam int unsigned DAY_OPEN     = 21600;
  localparam int unsigned DAY_CLOSE    = 64800;
  localparam int unsigned SEGMENT_SPAN = 7200;
  localparam int unsigned NIGHT_K      = 1900;
  localparam int unsigned FULL_PERCENT = 100;
  localparam int unsigned CURVE_BASE   = 19;
  localparam int unsigned CURVE_LAST   = 47;

  localparam int unsigned POINT_KELVIN [7] = '{1900, 3000, 4000, 6600, 4000, 3000, 1900};

  // Green and blue intensity per hundred kelvin, starting at 1900 K.
  localparam logic [7:0] GREEN_BY_STEP [48] = '{
    8'd131, 8'd136, 8'd141, 8'd146, 8'd150, 8'd155, 8'd159, 8'd162,
    8'd166, 8'd170, 8'd173, 8'd177, 8'd180, 8'd183, 8'd186, 8'd189,
    8'd192, 8'd195, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210,
    8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd223, 8'd226, 8'd228,
    8'd229, 8'd231, 8'd233, 8'd235, 8'd237, 8'd239, 8'd241, 8'd242,
    8'd244, 8'd246, 8'd247, 8'd249, 8'd251, 8'd252, 8'd254, 8'd255
  };
  localparam logic [7:0] BLUE_BY_STEP [48] = '{
    8'd0,   8'd13,  8'd27,  8'd39,  8'd50,  8'd60,  8'd70,  8'd79,
    8'd87,  8'd95,  8'd102, 8'd109, 8'd116, 8'd123, 8'd129, 8'd135,
    8'd140, 8'd146, 8'd151, 8'd156, 8'd161, 8'd166, 8'd170, 8'd175,
    8'd179, 8'd183, 8'd187, 8'd191, 8'd195, 8'd198, 8'd202, 8'd205,
    8'd209, 8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231,
    8'd234, 8'd236, 8'd239, 8'd242, 8'd244, 8'd247, 8'd255, 8'd255
  };

  // Segment edges used to aim random times at the interpolation corners.
  localparam int unsigned TIME_EDGES [8] = '{21600, 28800, 36000, 43200,
                                             50400, 57600, 64800, 86400};

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pace_t;

  typedef struct {
    logic [dctr_pkg::LevelW-1:0]  red;
    logic [dctr_pkg::LevelW-1:0]  green;
    logic [dctr_pkg::LevelW-1:0]  blue;
    logic [dctr_pkg::KelvinW-1:0] kelvin;
  } colour_t;

  // Holds the predicted colour for every accepted time sample, oldest first,
  // and compares each delivered colour against it.
  class colour_scoreboard;
    colour_t     pending_colours[$];
    int unsigned mismatches;
    int unsigned colours_checked;
    int unsigned samples_noted;
    int unsigned window_samples;

    function new();
      mismatches      = 0;
      colours_checked = 0;
      samples_noted   = 0;
      window_samples  = 0;
    endfunction

    // Interpolate the kelvin for a time, pick the curve step, scale by brightness.
    function colour_t predict_colour(input logic [dctr_pkg::SecondW-1:0] sec,
                                     input logic [dctr_pkg::BrightW-1:0] pct);
      int unsigned s, b, k, seg, d, lo, hi, step;
      colour_t c;
      s = 32'(sec);
      b = (32'(pct) > FULL_PERCENT) ? FULL_PERCENT : 32'(pct);
      if (s < DAY_OPEN || s >= DAY_CLOSE) begin
        k = NIGHT_K;
      end else begin
        seg = (s - DAY_OPEN) / SEGMENT_SPAN;
        if (seg > 5) seg = 5;
        d  = s - DAY_OPEN - seg * SEGMENT_SPAN;
        lo = POINT_KELVIN[3'(seg)];
        hi = POINT_KELVIN[3'(seg + 1)];
        if (hi >= lo) k = lo + (d * (hi - lo)) / SEGMENT_SPAN;
        else          k = lo - (d * (lo - hi)) / SEGMENT_SPAN;
      end
      step = k / 100;
      if (step < CURVE_BASE) step = CURVE_BASE;
      step = step - CURVE_BASE;
      if (step > CURVE_LAST) step = CURVE_LAST;
      c.red    = 8'((255 * b) / FULL_PERCENT);
      c.green  = 8'((32'(GREEN_BY_STEP[6'(step)]) * b) / FULL_PERCENT);
      c.blue   = 8'((32'(BLUE_BY_STEP[6'(step)]) * b) / FULL_PERCENT);
      c.kelvin = 13'(k);
      return c;
    endfunction

    function void note_sample(input logic [dctr_pkg::SecondW-1:0] sec,
                              input logic [dctr_pkg::BrightW-1:0] pct);
      pending_colours.push_back(predict_colour(sec, pct));
      samples_noted++;
      if (32'(sec) >= DAY_OPEN && 32'(sec) < DAY_CLOSE) window_samples++;
    endfunction

    function void check_result(input colour_t got);
      colour_t want;
      if (pending_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: colour with nothing pending: r=%0d g=%0d b=%0d k=%0d",
                   $time, got.red, got.green, got.blue, got.kelvin);
        return;
      end
      want = pending_colours.pop_front();
      colours_checked++;
      if (got.red != want.red || got.green != want.green ||
          got.blue != want.blue || got.kelvin != want.kelvin) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: colour mismatch: expected r=%0d g=%0d b=%0d k=%0d, got r=%0d g=%0d b=%0d k=%0d",
                   $time, want.red, want.green, want.blue, want.kelvin,
                   got.red, got.green, got.blue, got.kelvin);
      end
    endfunction

    function int unsigned outstanding();
      return pending_colours.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [dctr_pkg::SecondW-1:0]  in_second_of_day = '0;
  logic [dctr_pkg::BrightW-1:0]  in_brightness_percent = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [dctr_pkg::LevelW-1:0]   out_red_level;
  logic [dctr_pkg::LevelW-1:0]   out_green_level;
  logic [dctr_pkg::LevelW-1:0]   out_blue_level;
  logic [dctr_pkg::KelvinW-1:0]  out_colour_kelvin;

  colour_scoreboard ledger = new();
  int unsigned      cycle_count   = 0;
  int unsigned      hold_off_asks = 0;
  int unsigned      hold_off_done = 0;
  int unsigned      drains        = 0;

  daylight_colour_temperature_rgb_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_second_of_day      (in_second_of_day),
    .in_brightness_percent (in_brightness_percent),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_red_level         (out_red_level),
    .out_green_level       (out_green_level),
    .out_blue_level        (out_blue_level),
    .out_colour_kelvin     (out_colour_kelvin)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Abort a hung run: nothing correct takes this long.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d colours still pending",
               cycle_count, ledger.outstanding());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every output transfer; sampling at the rising edge sees pre-edge values.
  always @(posedge clk) begin : take_colour
    colour_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.red    = out_red_level;
      got.green  = out_green_level;
      got.blue   = out_blue_level;
      got.kelvin = out_colour_kelvin;
      ledger.check_result(got);
    end
  end

  // Output back-pressure. Switch between pacing styles picked at random,
  // and on request hold stall high for a long stretch so the pipeline fills up
  // and pushes back on the input side.
  initial begin : output_pacing
    stall_pace_t pace;
    int unsigned pace_left;
    int unsigned hold_left;
    int unsigned beat;
    pace      = STALL_NONE;
    pace_left = 0;
    hold_left = 0;
    beat      = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_off_asks > hold_off_done) begin
        hold_off_done++;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        if (pace_left == 0) begin
          pace      = stall_pace_t'($urandom_range(0, 3));
          pace_left = $urandom_range(20, 150);
        end
        pace_left--;
        case (pace)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
          STALL_PERIODIC: out_stall <= ((beat % 5) >= 3);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Offer one sample and hold it until the block takes it. Returns right
  // after the accepting edge, so back-to-back calls keep valid high.
  task automatic send_sample(input logic [dctr_pkg::SecondW-1:0] sec,
                             input logic [dctr_pkg::BrightW-1:0] pct);
    @(negedge clk);
    in_valid              <= 1'b1;
    in_second_of_day      <= sec;
    in_brightness_percent <= pct;
    do @(posedge clk); while (in_stall);
    ledger.note_sample(sec, pct);
  endtask

  // Drop valid for the requested idle time; scramble the idle payload while at it.
  task automatic idle_for(input int unsigned cycles);
    @(negedge clk);
    in_valid              <= 1'b0;
    in_second_of_day      <= 17'($urandom_range(0, (1 << dctr_pkg::SecondW) - 1));
    in_brightness_percent <= 7'($urandom_range(0, (1 << dctr_pkg::BrightW) - 1));
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted colour has come back.
  task automatic wait_all_delivered();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  // Mostly daylight times, some aimed at segment edges, some anywhere in 17 bits.
  function automatic logic [dctr_pkg::SecondW-1:0] pick_second();
    int unsigned roll;
    int          aimed;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 17'($urandom_range(DAY_OPEN, DAY_CLOSE - 1));
    if (roll < 70) return 17'($urandom_range(0, 86399));
    if (roll < 85) begin
      aimed = int'(TIME_EDGES[3'($urandom_range(0, 7))]) + $urandom_range(0, 6) - 3;
      return 17'(aimed);
    end
    return 17'($urandom_range(0, (1 << dctr_pkg::SecondW) - 1));
  endfunction

  // Brightness: mostly anywhere, with extra weight around the saturation point and at the extremes.
  function automatic logic [dctr_pkg::BrightW-1:0] pick_brightness();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 7'($urandom_range(0, 127));
    if (roll < 85) return 7'($urandom_range(97, 104));
    return ($urandom_range(0, 1) == 1) ? 7'd127 : 7'($urandom_range(0, 2));
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned burst_left;
    int unsigned gap_len;
    burst_left = 0;

    // Hold reset and release it away from the clock edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: midnight, window edges, segment corners, the noon peak where
    // blue saturates, exactly 18:00, times past the end of the day, and
    // brightness at zero, one, just below, at and above the saturation point.
    send_sample(17'd0,      7'd100);
    send_sample(17'd21599,  7'd127);
    send_sample(17'd21600,  7'd100);
    send_sample(17'd21601,  7'd50);
    send_sample(17'd28799,  7'd99);
    send_sample(17'd28800,  7'd101);
    send_sample(17'd35999,  7'd1);
    send_sample(17'd36000,  7'd0);
    send_sample(17'd43000,  7'd100);
    send_sample(17'd43199,  7'd100);
    send_sample(17'd43200,  7'd100);
    send_sample(17'd43201,  7'd100);
    send_sample(17'd50399,  7'd64);
    send_sample(17'd50400,  7'd127);
    send_sample(17'd57599,  7'd100);
    send_sample(17'd57600,  7'd33);
    send_sample(17'd64799,  7'd100);
    send_sample(17'd64800,  7'd100);
    send_sample(17'd64801,  7'd100);
    send_sample(17'd86399,  7'd127);
    send_sample(17'd86400,  7'd100);
    send_sample(17'd65536,  7'd85);
    send_sample(17'd131071, 7'd127);
    wait_all_delivered();
    drains++;

    // Random: bursts of back-to-back transfers separated by random gaps.
    for (n = 0; n < RANDOM_SAMPLES; n++) begin
      // Ask for one long output hold-off while input keeps flowing.
      if (n == 700) hold_off_asks++;
      // At sample 1400, let the pipeline run dry once.
      if (n == 1400) begin
        wait_all_delivered();
        drains++;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        if (gap_len > 0 && n != 700) idle_for(gap_len);
      end
      burst_left--;
      send_sample(pick_second(), pick_brightness());
    end

    // Drain, then give the pipeline time to show any stray output.
    wait_all_delivered();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (ledger.outstanding() != 0)
      $display("%0d predicted colours never arrived", ledger.outstanding());
    $display("covered %0d time samples (%0d in the daylight window), %0d colours compared",
             ledger.samples_noted, ledger.window_samples, ledger.colours_checked);
    $display("output held off %0d time(s) for %0d cycles, pipeline drained %0d time(s), %0d mismatches",
             hold_off_done, LONG_HOLD, drains, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/dctr_pkg.sv
hw/rtl/dctr_kelvin.sv
hw/rtl/dctr_colour.sv
hw/rtl/daylight_colour_temperature_rgb_unit.sv
hw/rtl/dctr_checker.sv
tb/sv/tb_daylight_colour_temperature_rgb_unit.sv
